### rtl/rrpt_pkg.sv
// ----------------------------------------------------------------------------
// rrpt_pkg - shared types and constants of the round-robin process table
// Slot record layout, operation and status codes, job and verdict bundles.
// ----------------------------------------------------------------------------
package rrpt_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [15:0] SP_RESET = 16'hff00;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_READY   = 2'd1,
      ST_WAITING = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_SPAWN     = 3'd1,
      OP_KILL      = 3'd2,
      OP_WAIT      = 3'd3,
      OP_TERMINATE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_READY   = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_NO_CURRENT = 2'd3
   } status_type;

   typedef struct packed {
      slot_state_type      state;
      logic [15:0]         sp;
      logic [SLOT_W-1:0]   wf;
   } slot_rec_type;

   // One accepted item plus the scheduler context it runs against.
   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   target_id;
      logic                target_ok;
      logic [15:0]         sp_in;
      logic [SLOT_W-1:0]   cur_slot;
      logic                cur_valid;
      logic [SLOT_W:0]     scan_start;
   } job_type;

   typedef struct packed {
      status_type          status;
      logic                named;
      logic [SLOT_W-1:0]   slot;
      logic [15:0]         sp;
   } verdict_type;

   // Segment of a slot: (slot+2)*0x1000, low 16 bits.
   function automatic logic [15:0] seg_of(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W:0] s2;
      logic [31:0]     w;
      s2 = {1'b0, slot} + (SLOT_W+1)'(2);
      w  = 32'(s2) << 12;
      return w[15:0];
   endfunction

   // Low three bits of a slot number.
   function automatic logic [2:0] slot_bits(input logic [SLOT_W-1:0] slot);
      logic [31:0] w;
      w = 32'(slot);
      return w[2:0];
   endfunction

endpackage

### rtl/rrpt_cell.sv
// ----------------------------------------------------------------------------
// rrpt_cell - one link of the slot ring
// Holds one slot record and takes its neighbour's record on each shift.
// ----------------------------------------------------------------------------
module rrpt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  rrpt_pkg::slot_rec_type nbr_rec,
   output rrpt_pkg::slot_rec_type rec
);

   rrpt_pkg::slot_rec_type rec_ff;
   rrpt_pkg::slot_rec_type rec_in;

   always_comb begin
      rec_in = shift_en ? nbr_rec : rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.state <= rrpt_pkg::ST_FREE;
         rec_ff.sp    <= rrpt_pkg::SP_RESET;
         rec_ff.wf    <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

### rtl/rrpt_head.sv
// ----------------------------------------------------------------------------
// rrpt_head - edit and search stage at the ring's exit
// Edits the record leaving cell 0 for the current item and tracks the
// round-robin and lowest-free searches over one revolution.
// ----------------------------------------------------------------------------
module rrpt_head (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         step_en,
   input  rrpt_pkg::job_type            job,
   input  logic [rrpt_pkg::SLOT_W-1:0]  step,
   input  logic [15:0]                  init_sp,
   input  rrpt_pkg::slot_rec_type       rec_from_ring,
   output rrpt_pkg::slot_rec_type       rec_to_ring,
   output rrpt_pkg::verdict_type        verdict
);

   logic                        first_hit_ff, first_hit_in;
   logic [rrpt_pkg::SLOT_W-1:0] first_slot_ff, first_slot_in;
   logic [15:0]                 first_sp_ff, first_sp_in;
   logic                        after_hit_ff, after_hit_in;
   logic [rrpt_pkg::SLOT_W-1:0] after_slot_ff, after_slot_in;
   logic [15:0]                 after_sp_ff, after_sp_in;
   logic                        cur_ok_ff, cur_ok_in;

   logic                        is_cur;
   logic                        is_ready;
   logic                        is_free;
   logic [rrpt_pkg::SLOT_W-1:0] victim;
   logic                        victim_ok;

   assign is_cur   = job.cur_valid && (step == job.cur_slot);
   assign is_ready = (rec_from_ring.state == rrpt_pkg::ST_READY);
   assign is_free  = (rec_from_ring.state == rrpt_pkg::ST_FREE);
   assign victim    = (job.op == rrpt_pkg::OP_TERMINATE) ? job.cur_slot : job.target_id;
   assign victim_ok = (job.op == rrpt_pkg::OP_TERMINATE) ? job.cur_valid : job.target_ok;

   // record edit
   always_comb begin
      rec_to_ring = rec_from_ring;
      case (job.op) inside
         rrpt_pkg::OP_TICK: begin
            if (is_cur) rec_to_ring.sp = job.sp_in;
         end
         rrpt_pkg::OP_SPAWN: begin
            if (!first_hit_ff && is_free) begin
               rec_to_ring.state = rrpt_pkg::ST_READY;
               rec_to_ring.sp    = init_sp;
            end
         end
         rrpt_pkg::OP_KILL, rrpt_pkg::OP_TERMINATE: begin
            if (victim_ok) begin
               if (step == victim) begin
                  rec_to_ring.state = rrpt_pkg::ST_FREE;
               end else if (rec_from_ring.state == rrpt_pkg::ST_WAITING &&
                            rec_from_ring.wf == victim) begin
                  rec_to_ring.state = rrpt_pkg::ST_READY;
               end
            end
         end
         rrpt_pkg::OP_WAIT: begin
            if (is_cur && is_ready && job.target_ok) begin
               rec_to_ring.state = rrpt_pkg::ST_WAITING;
               rec_to_ring.wf    = job.target_id;
            end
         end
         default: begin
         end
      endcase
   end

   // search bookkeeping
   always_comb begin
      first_hit_in  = first_hit_ff;
      first_slot_in = first_slot_ff;
      first_sp_in   = first_sp_ff;
      after_hit_in  = after_hit_ff;
      after_slot_in = after_slot_ff;
      after_sp_in   = after_sp_ff;
      cur_ok_in     = cur_ok_ff;
      if (clear) begin
         first_hit_in = 1'b0;
         after_hit_in = 1'b0;
         cur_ok_in    = 1'b0;
      end else if (step_en) begin
         case (job.op) inside
            rrpt_pkg::OP_TICK: begin
               if (is_ready && !first_hit_ff) begin
                  first_hit_in  = 1'b1;
                  first_slot_in = step;
                  first_sp_in   = rec_to_ring.sp;
               end
               if (is_ready && !after_hit_ff && ({1'b0, step} >= job.scan_start)) begin
                  after_hit_in  = 1'b1;
                  after_slot_in = step;
                  after_sp_in   = rec_to_ring.sp;
               end
            end
            rrpt_pkg::OP_SPAWN: begin
               if (is_free && !first_hit_ff) begin
                  first_hit_in  = 1'b1;
                  first_slot_in = step;
                  first_sp_in   = init_sp;
               end
            end
            rrpt_pkg::OP_WAIT: begin
               if (is_cur && is_ready) cur_ok_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_hit_ff <= 1'b0;
         after_hit_ff <= 1'b0;
         cur_ok_ff    <= 1'b0;
      end else begin
         first_hit_ff <= first_hit_in;
         after_hit_ff <= after_hit_in;
         cur_ok_ff    <= cur_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      first_slot_ff <= first_slot_in;
      first_sp_ff   <= first_sp_in;
      after_slot_ff <= after_slot_in;
      after_sp_ff   <= after_sp_in;
   end

   // final answer, valid once the revolution is complete
   always_comb begin
      verdict.status = rrpt_pkg::STAT_OK;
      verdict.named  = 1'b0;
      verdict.slot   = first_slot_ff;
      verdict.sp     = first_sp_ff;
      case (job.op) inside
         rrpt_pkg::OP_TICK: begin
            if (after_hit_ff) begin
               verdict.named = 1'b1;
               verdict.slot  = after_slot_ff;
               verdict.sp    = after_sp_ff;
            end else if (first_hit_ff) begin
               verdict.named = 1'b1;
            end else begin
               verdict.status = rrpt_pkg::STAT_NO_READY;
            end
         end
         rrpt_pkg::OP_SPAWN: begin
            if (first_hit_ff) verdict.named = 1'b1;
            else verdict.status = rrpt_pkg::STAT_FULL;
         end
         rrpt_pkg::OP_WAIT: begin
            if (!cur_ok_ff) verdict.status = rrpt_pkg::STAT_NO_CURRENT;
         end
         rrpt_pkg::OP_TERMINATE: begin
            if (!job.cur_valid) verdict.status = rrpt_pkg::STAT_NO_CURRENT;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/round_robin_process_table.sv
// ----------------------------------------------------------------------------
// round_robin_process_table - eight-slot round-robin process table
// Ring of slot cells rotated past an edit/search head, one item at a time.
// ----------------------------------------------------------------------------
// Each item runs from its accept cycle through one ring revolution, in which
// each slot record passes the head once, to a done state that hands the
// result to the output register; the next item is taken only after that.
// The ring's single exit point passes one record per cycle during a sweep.
// req_ready is high whenever no item is in progress, even while a result
// still sits in the output register; an item finished while that register
// is full waits in place. initial_stack_pointer answers at byte addresses
// 0 to 3 (resets to 0xff00); other addresses read zero and ignore writes.
// The table itself resets to all slots free with no current process.
module round_robin_process_table (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [2:0]  req_target_slot,
   input  logic [15:0] req_stack_pointer_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_result_slot,
   output logic [15:0] rsp_segment_out,
   output logic [15:0] rsp_stack_pointer_out,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW = rrpt_pkg::SLOT_W;
   localparam logic [SW-1:0] LAST_STEP = SW'(rrpt_pkg::SLOT_COUNT - 1);
   localparam logic CSR_IDX_INIT_SP = 1'b0;   // word index of the one register

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SWEEP = 3'b010,
      S_DONE  = 3'b100
   } fsm_type;

   fsm_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   rrpt_pkg::job_type job_ff, job_in;

   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic          cur_valid_ff, cur_valid_in;

   logic [15:0]   init_sp_ff, init_sp_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [2:0]    rsp_slot_ff, rsp_slot_in;
   logic [15:0]   rsp_seg_ff, rsp_seg_in;
   logic [15:0]   rsp_sp_ff, rsp_sp_in;

   logic          accept;
   logic          sweeping;
   logic          deliver;
   logic          csr_wr;

   rrpt_pkg::slot_rec_type ring [rrpt_pkg::SLOT_COUNT];
   rrpt_pkg::slot_rec_type head_out;
   rrpt_pkg::verdict_type  verdict;

   // ---- handshakes ---------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign sweeping  = (state_ff == S_SWEEP);
   // finished item moves out once the output register is free or emptying
   assign deliver   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // ---- configuration port -------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_IDX_INIT_SP);
   assign init_sp_in = csr_wr ? csr_pwdata[15:0] : init_sp_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_INIT_SP) ? {16'd0, init_sp_ff} : 32'd0;

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (accept) state_in = S_SWEEP;
         end
         S_SWEEP: begin
            // record of slot step_ff sits at the ring exit this cycle
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         S_DONE: begin
            if (deliver) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // capture the item together with the scheduler context it runs against
   always_comb begin
      job_in = job_ff;
      if (accept) begin
         job_in.op         = rrpt_pkg::op_type'(req_operation);
         job_in.target_id  = SW'(req_target_slot);
         job_in.target_ok  = (32'(req_target_slot) < rrpt_pkg::SLOT_COUNT);
         job_in.sp_in      = req_stack_pointer_in;
         job_in.cur_slot   = cur_slot_ff;
         job_in.cur_valid  = cur_valid_ff;
         // round-robin scan starts just past the running slot
         job_in.scan_start = cur_valid_ff ? ({1'b0, cur_slot_ff} + (SW+1)'(1)) : '0;
      end
   end

   // a successful tick makes the chosen slot current
   always_comb begin
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      if (deliver && job_ff.op == rrpt_pkg::OP_TICK && verdict.named) begin
         cur_slot_in  = verdict.slot;
         cur_valid_in = 1'b1;
      end
   end

   // ---- output register ----------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_sp_in     = rsp_sp_ff;
      if (deliver) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = verdict.status;
         // fields that name no slot read zero
         rsp_slot_in   = verdict.named ? rrpt_pkg::slot_bits(verdict.slot) : 3'd0;
         rsp_seg_in    = verdict.named ? rrpt_pkg::seg_of(verdict.slot) : 16'd0;
         rsp_sp_in     = verdict.named ? verdict.sp : 16'd0;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_result_slot       = rsp_slot_ff;
   assign rsp_segment_out       = rsp_seg_ff;
   assign rsp_stack_pointer_out = rsp_sp_ff;

   // ---- registers ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         init_sp_ff   <= rrpt_pkg::SP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         init_sp_ff   <= init_sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_sp_ff     <= rsp_sp_in;
   end

   // ---- slot ring ----------------------------------------------------------
   // At rest cell k holds slot k. During a sweep every cell takes its upper
   // neighbour's record and the last cell takes the head's edited record, so
   // after one full revolution every record is back home.
   for (genvar g = 0; g < rrpt_pkg::SLOT_COUNT; g++) begin : g_ring
      rrpt_pkg::slot_rec_type nbr;
      if (g == rrpt_pkg::SLOT_COUNT - 1) begin : g_tail
         assign nbr = head_out;
      end else begin : g_link
         assign nbr = ring[g+1];
      end
      rrpt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (sweeping),
         .nbr_rec  (nbr),
         .rec      (ring[g])
      );
   end

   rrpt_head u_head (
      .clock         (clock),
      .reset         (reset),
      .clear         (accept),
      .step_en       (sweeping),
      .job           (job_ff),
      .step          (step_ff),
      .init_sp       (init_sp_ff),
      .rec_from_ring (ring[0]),
      .rec_to_ring   (head_out),
      .verdict       (verdict)
   );

   // ---- assertions ---------------------------------------------------------
   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SWEEP) && (step_ff == '0))
      else $error("accepted item did not start a ring sweep");

   a_sweep_ends_in_done: assert property (@(posedge clock) disable iff (reset)
      (sweeping && step_ff == LAST_STEP) |=> (state_ff == S_DONE))
      else $error("ring sweep did not end after one revolution");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result appeared without a finished item");

   a_current_sticks: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |=> cur_valid_ff)
      else $error("current process marker dropped");

   a_idle_step_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (step_ff == '0))
      else $error("ring not at rest while idle");

endmodule

### test/round_robin_process_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_table_tb - self-checking bench for the process table
// Drives scheduler calls (tick, spawn, kill, wait, terminate, spare codes)
// over a valid/ready channel, predicts every reply with a local copy of the
// slot table, and compares replies field by field. The initial stack
// pointer register is set over the CSR port between phases of traffic.
// ----------------------------------------------------------------------------
module round_robin_process_table_tb;
   import rrpt_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int QUIET_LIMIT      = 4000;  // cycles without any handshake
   localparam int RANDOM_PER_PHASE = 360;
   localparam int LONG_HOLD        = 400;   // reply side held off this long once
   localparam int DRAIN_CYCLES     = 40;
   localparam int MAX_REPORTS      = 10;

   localparam logic [2:0]  CSR_INIT_SP = 3'd0;   // byte address of the register
   localparam logic [2:0]  OP_SPARE_LO = 3'd5;   // codes with no meaning
   localparam logic [2:0]  OP_SPARE_HI = 3'd7;
   localparam logic [15:0] SEG_STEP    = 16'h1000;

   // who idles, and how often
   typedef enum int {
      PACE_RSP_SLOW,   // sender 14 %, receiver 76 %
      PACE_REQ_SLOW,   // sender 76 %, receiver 14 %
      PACE_FULL        // nobody idles
   } pacing_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  target;
      logic [15:0] sp;
   } sched_call_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic [15:0] seg;
      logic [15:0] sp;
   } sched_reply_type;

   // -------------------------------------------------------------------------
   // DUT signals, every input known from time zero
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid            = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation        = '0;
   logic [2:0]  req_target_slot      = '0;
   logic [15:0] req_stack_pointer_in = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_result_slot;
   logic [15:0] rsp_segment_out;
   logic [15:0] rsp_stack_pointer_out;

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   round_robin_process_table u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_target_slot       (req_target_slot),
      .req_stack_pointer_in  (req_stack_pointer_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_result_slot       (rsp_result_slot),
      .rsp_segment_out       (rsp_segment_out),
      .rsp_stack_pointer_out (rsp_stack_pointer_out),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Local copy of the slot table
   // -------------------------------------------------------------------------
   slot_state_type    tbl_state   [SLOT_COUNT];
   logic [15:0]       tbl_sp      [SLOT_COUNT];
   logic [SLOT_W-1:0] tbl_waits_on[SLOT_COUNT];
   logic [SLOT_W-1:0] run_slot;
   logic              run_valid;
   logic [15:0]       spawn_sp;

   // bench bookkeeping
   sched_call_type  pending_calls[$];      // filled by the sequence, drained by the driver
   sched_reply_type predicted_replies[$];  // oldest first
   sched_call_type  on_offer;
   pacing_type      pacing        = PACE_RSP_SLOW;
   int              rsp_hold_left = 0;
   int              mismatches    = 0;
   int              quiet_cycles  = 0;
   int              op_count   [8];
   int              status_seen[4];

   function automatic bit roll(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic sched_reply_type named_reply(input int slot);
      sched_reply_type r;
      r.status = STAT_OK;
      r.slot   = 3'(slot);
      r.seg    = 16'((slot + 2) * int'(SEG_STEP));
      r.sp     = tbl_sp[slot];
      return r;
   endfunction

   // Free a slot, then wake whoever was waiting on it. Only waiting slots wake.
   function automatic void release_slot(input int victim);
      tbl_state[victim] = ST_FREE;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (tbl_state[i] == ST_WAITING && int'(tbl_waits_on[i]) == victim)
            tbl_state[i] = ST_READY;
   endfunction

   // Applies one call to the local table and returns the reply it must give.
   function automatic sched_reply_type schedule_call(input sched_call_type c);
      sched_reply_type r;
      int              first;
      int              cand;
      bit              found;
      r     = '0;
      found = 1'b0;
      case (c.op)
         OP_TICK: begin
            // interrupted pointer saved even if that slot was killed meanwhile
            if (run_valid)
               tbl_sp[run_slot] = c.sp;
            first    = run_valid ? int'(run_slot) + 1 : 0;
            r.status = STAT_NO_READY;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               cand = (first + i) % SLOT_COUNT;
               if (!found && tbl_state[cand] == ST_READY) begin
                  found     = 1'b1;
                  run_slot  = SLOT_W'(cand);
                  run_valid = 1'b1;
                  r         = named_reply(cand);
               end
            end
         end
         OP_SPAWN: begin
            r.status = STAT_FULL;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && tbl_state[i] == ST_FREE) begin
                  found        = 1'b1;
                  tbl_state[i] = ST_READY;
                  tbl_sp[i]    = spawn_sp;
                  r            = named_reply(i);
               end
            end
         end
         OP_KILL: begin
            if (int'(c.target) < SLOT_COUNT)
               release_slot(int'(c.target));
         end
         OP_WAIT: begin
            if (!run_valid || tbl_state[run_slot] != ST_READY) begin
               r.status = STAT_NO_CURRENT;
            end else if (int'(c.target) < SLOT_COUNT) begin
               tbl_state[run_slot]    = ST_WAITING;
               tbl_waits_on[run_slot] = SLOT_W'(c.target);
            end
         end
         OP_TERMINATE: begin
            if (!run_valid)
               r.status = STAT_NO_CURRENT;
            else
               release_slot(int'(run_slot));
         end
         default: ;   // spare codes: no change, plain ok
      endcase
      return r;
   endfunction

   function automatic void flag_mismatch(input string what, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
   endfunction

   function automatic void check_reply();
      sched_reply_type want;
      status_seen[rsp_status]++;
      if (predicted_replies.size() == 0) begin
         flag_mismatch("reply with nothing outstanding", '0, 32'(rsp_status));
      end else begin
         want = predicted_replies.pop_front();
         if (rsp_status != want.status)
            flag_mismatch("status", 32'(want.status), 32'(rsp_status));
         if (rsp_result_slot != want.slot)
            flag_mismatch("result slot", 32'(want.slot), 32'(rsp_result_slot));
         if (rsp_segment_out != want.seg)
            flag_mismatch("segment", 32'(want.seg), 32'(rsp_segment_out));
         if (rsp_stack_pointer_out != want.sp)
            flag_mismatch("stack pointer", 32'(want.sp), 32'(rsp_stack_pointer_out));
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver: presents queued calls, predicts each one as it is taken
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_replies.push_back(schedule_call(on_offer));
            op_count[on_offer.op]++;
         end
         // a held item stays put until taken
         if (!req_valid || req_ready) begin
            if (pending_calls.size() != 0 &&
                !roll(pacing == PACE_RSP_SLOW ? 14 : pacing == PACE_REQ_SLOW ? 76 : 0)) begin
               on_offer             = pending_calls.pop_front();
               req_valid            <= 1'b1;
               req_operation        <= on_offer.op;
               req_target_slot      <= on_offer.target;
               req_stack_pointer_in <= on_offer.sp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks replies and paces rsp_ready; a long hold-off, when
   // requested, is counted down here so the table backs up into req_ready
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_reply();
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !roll(pacing == PACE_RSP_SLOW ? 76 : pacing == PACE_REQ_SLOW ? 14 : 0);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: any handshake, on either channel or the CSR port, resets it
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence helpers
   // -------------------------------------------------------------------------
   function automatic void push_call(input logic [2:0] op, input logic [2:0] target,
                                     input logic [15:0] sp);
      sched_call_type c;
      c.op     = op;
      c.target = target;
      c.sp     = sp;
      pending_calls.push_back(c);
   endfunction

   // Mostly ticks and table edits in roughly balanced measure, so the table
   // fills, drains and parks slots; a few spare codes as noise.
   function automatic sched_call_type random_call();
      sched_call_type c;
      int             pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      c.op = OP_TICK;
      else if (pick < 55) c.op = OP_SPAWN;
      else if (pick < 70) c.op = OP_KILL;
      else if (pick < 85) c.op = OP_WAIT;
      else if (pick < 95) c.op = OP_TERMINATE;
      else                c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      c.target = 3'($urandom_range(0, SLOT_COUNT - 1));
      case ($urandom_range(0, 7))
         0:       c.sp = 16'h0000;
         1:       c.sp = 16'hffff;
         default: c.sp = 16'($urandom);
      endcase
      return c;
   endfunction

   // nothing queued, nothing on offer, nothing outstanding
   task automatic wait_settled();
      while (pending_calls.size() != 0 || req_valid || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   // setup cycle, then access cycle; the transfer completes at the end of the access cycle
   task automatic csr_access(input bit write, input logic [2:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      if (write && addr == CSR_INIT_SP)
         spawn_sp = data[15:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write, then read back
   task automatic set_spawn_sp(input logic [15:0] value);
      logic [31:0] readback;
      csr_access(1'b1, CSR_INIT_SP, 32'(value), readback);
      csr_access(1'b0, CSR_INIT_SP, '0, readback);
      if (readback[15:0] != value)
         flag_mismatch("initial stack pointer readback", 32'(value), readback);
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [15:0] mid_sp;

      for (int i = 0; i < SLOT_COUNT; i++) begin
         tbl_state[i]    = ST_FREE;
         tbl_sp[i]       = SP_RESET;
         tbl_waits_on[i] = '0;
      end
      run_slot  = '0;
      run_valid = 1'b0;
      spawn_sp  = SP_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table first, then fill it to the brim, then walk
      // through parking, waking and terminating.
      push_call(OP_TICK,      3'd0, 16'h1111);   // nothing ready
      push_call(OP_WAIT,      3'd3, 16'h0000);   // no running process
      push_call(OP_TERMINATE, 3'd0, 16'h0000);   // no running process
      push_call(OP_KILL,      3'd7, 16'h0000);   // killing a free slot
      push_call(OP_SPARE_LO,  3'd7, 16'hffff);
      push_call(OP_SPARE_HI,  3'd0, 16'h0000);
      for (int i = 0; i <= SLOT_COUNT; i++)      // last one finds the table full
         push_call(OP_SPAWN, 3'd0, 16'h0000);
      push_call(OP_TICK,      3'd0, 16'hffff);   // no current: scan from slot 0
      push_call(OP_TICK,      3'd0, 16'h0000);   // saves slot 0, picks slot 1
      push_call(OP_WAIT,      3'd0, 16'h0000);   // slot 1 parks on slot 0
      push_call(OP_TICK,      3'd0, 16'h1234);
      push_call(OP_KILL,      3'd0, 16'h0000);   // frees 0, wakes 1
      push_call(OP_TERMINATE, 3'd0, 16'h0000);   // current slot goes
      push_call(OP_TICK,      3'd5, 16'habcd);   // pointer stored for a dead slot
      push_call(OP_SPAWN,     3'd0, 16'h0000);   // lowest free is slot 0
      push_call(OP_WAIT,      3'd7, 16'h0000);
      push_call(OP_WAIT,      3'd6, 16'h0000);   // current already parked
      push_call(OP_KILL,      3'd7, 16'h0000);   // wakes the parked slot
      push_call(OP_TICK,      3'd2, 16'h8001);
      wait_settled();

      // Random, sender rarely idle, receiver mostly stalling
      set_spawn_sp(16'h0000);
      pacing = PACE_RSP_SLOW;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         pending_calls.push_back(random_call());
      wait_settled();

      // Random, the other way round
      set_spawn_sp(16'hffff);
      pacing = PACE_REQ_SLOW;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         pending_calls.push_back(random_call());
      wait_settled();

      // Random at full rate, opening with a long reply-side hold-off while
      // calls keep coming, so the table backs up and stalls its input
      mid_sp = 16'($urandom);
      set_spawn_sp(mid_sp);
      pacing        = PACE_FULL;
      rsp_hold_left = LONG_HOLD;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         pending_calls.push_back(random_call());
      wait_settled();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d tick, %0d spawn, %0d kill, %0d wait, %0d terminate, %0d spare",
               op_count[OP_TICK], op_count[OP_SPAWN], op_count[OP_KILL], op_count[OP_WAIT],
               op_count[OP_TERMINATE], op_count[5] + op_count[6] + op_count[7]);
      $display("replies ok %0d, none ready %0d, full %0d, no current %0d; spawn sp ff00/0000/ffff/%h",
               status_seen[STAT_OK], status_seen[STAT_NO_READY], status_seen[STAT_FULL],
               status_seen[STAT_NO_CURRENT], mid_sp);
      if (mismatches == 0 && predicted_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
